@@ hw/rtl/lorenz_euler_stepper_core_defines.svh @@
// ----------------------------------------------------------------------------
// Lorenz Euler stepper assertion macros
// Shared property wrappers for the checker of the stepper core. Every macro
// samples on clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LORENZ_EULER_STEPPER_CORE_DEFINES_SVH
`define LORENZ_EULER_STEPPER_CORE_DEFINES_SVH

// Same-cycle implication.
`define LORENZ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LORENZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lorenz_pkg.sv @@
// ----------------------------------------------------------------------------
// Lorenz stepper package
// Fixed-point constants, datapath codes, the control word layout and the
// microcode program of the Lorenz Euler stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package lorenz_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned STEP_W    = 10;
  localparam int unsigned RUN_W     = 11;
  localparam int unsigned CFG_IDX_W = 3;

  localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
  // dt = 0.01, rounded to the nearest fixed-point code.
  localparam logic signed [DATA_W-1:0] DT_Q = DATA_W'((ONE_Q + 50) / 100);

  localparam logic signed [DATA_W-1:0] MAX_Q = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_Q = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [RUN_W-1:0] MAX_RUN = RUN_W'(1024);

  // Reset values of the configuration registers.
  localparam logic signed [DATA_W-1:0] SIGMA_RST   = DATA_W'(10 * ONE_Q);
  localparam logic signed [DATA_W-1:0] RHO_RST     = DATA_W'(28 * ONE_Q);
  localparam logic signed [DATA_W-1:0] BETA_RST    = DATA_W'((8 * ONE_Q + 1) / 3);
  localparam logic signed [DATA_W-1:0] START_RST   = DATA_W'(ONE_Q);
  localparam logic [RUN_W-1:0]         RUN_LEN_RST = RUN_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIGMA      = 3'd0,
    CFG_RHO        = 3'd1,
    CFG_BETA       = 3'd2,
    CFG_START_X    = 3'd3,
    CFG_START_Y    = 3'd4,
    CFG_START_Z    = 3'd5,
    CFG_RUN_LENGTH = 3'd6
  } cfg_idx_e;

  // Operand sources of the datapath.
  typedef enum logic [3:0] {
    SRC_X     = 4'd0,
    SRC_Y     = 4'd1,
    SRC_Z     = 4'd2,
    SRC_T0    = 4'd3,
    SRC_T1    = 4'd4,
    SRC_T2    = 4'd5,
    SRC_T3    = 4'd6,
    SRC_SIGMA = 4'd7,
    SRC_RHO   = 4'd8,
    SRC_BETA  = 4'd9,
    SRC_DT    = 4'd10
  } src_e;

  // Writable registers of the datapath.
  typedef enum logic [2:0] {
    DST_X  = 3'd0,
    DST_Y  = 3'd1,
    DST_Z  = 3'd2,
    DST_T0 = 3'd3,
    DST_T1 = 3'd4,
    DST_T2 = 3'd5,
    DST_T3 = 3'd6
  } dst_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // WAIT_IN holds until an input beat, DONE holds until the output slot is free.
  typedef enum logic [1:0] {
    JMP_NEXT    = 2'd0,
    JMP_WAIT_IN = 2'd1,
    JMP_DONE    = 2'd2
  } jump_e;

  // Datapath control: one multiply slot and one add/subtract slot per cycle.
  typedef struct packed {
    logic    mul_en;
    src_e    mul_a;
    src_e    mul_b;
    dst_e    mul_dst;
    logic    alu_en;
    alu_op_e alu_op;
    src_e    alu_a;
    src_e    alu_b;
    dst_e    alu_dst;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    jump_e jump;
  } uword_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic in_ready;
    logic done;
  } seq_stat_t;

  localparam int unsigned UC_DEPTH = 10;
  localparam int unsigned UC_AW    = $clog2(UC_DEPTH);
  localparam logic [UC_AW-1:0] UC_ENTRY = UC_AW'(0);

  function automatic uword_t uw(input logic mul_en, input src_e mul_a, input src_e mul_b,
                                input dst_e mul_dst, input logic alu_en,
                                input alu_op_e alu_op, input src_e alu_a,
                                input src_e alu_b, input dst_e alu_dst,
                                input jump_e jump);
    uword_t w;
    w.ctrl.mul_en  = mul_en;
    w.ctrl.mul_a   = mul_a;
    w.ctrl.mul_b   = mul_b;
    w.ctrl.mul_dst = mul_dst;
    w.ctrl.alu_en  = alu_en;
    w.ctrl.alu_op  = alu_op;
    w.ctrl.alu_a   = alu_a;
    w.ctrl.alu_b   = alu_b;
    w.ctrl.alu_dst = alu_dst;
    w.jump         = jump;
    return w;
  endfunction

  // The step program. T0..T3 are scratch; X, Y, Z are only overwritten once
  // every product that needs the old point has been formed.
  function automatic uword_t ucode(input logic [UC_AW-1:0] addr);
    uword_t w;
    case (addr)
      4'd0: w = uw(1'b0, SRC_X, SRC_X, DST_T0, 1'b0, ALU_ADD, SRC_X, SRC_X, DST_T0,
                   JMP_WAIT_IN);
      // T0 = y - x, T2 = x*y
      4'd1: w = uw(1'b1, SRC_X, SRC_Y, DST_T2, 1'b1, ALU_SUB, SRC_Y, SRC_X, DST_T0,
                   JMP_NEXT);
      // T1 = rho - z, T3 = beta*z
      4'd2: w = uw(1'b1, SRC_BETA, SRC_Z, DST_T3, 1'b1, ALU_SUB, SRC_RHO, SRC_Z, DST_T1,
                   JMP_NEXT);
      // T0 = sigma*(y - x), T2 = x*y - beta*z
      4'd3: w = uw(1'b1, SRC_SIGMA, SRC_T0, DST_T0, 1'b1, ALU_SUB, SRC_T2, SRC_T3, DST_T2,
                   JMP_NEXT);
      // T1 = x*(rho - z)
      4'd4: w = uw(1'b1, SRC_X, SRC_T1, DST_T1, 1'b0, ALU_ADD, SRC_X, SRC_X, DST_T0,
                   JMP_NEXT);
      // T0 = dt*fx, T1 = x*(rho - z) - y
      4'd5: w = uw(1'b1, SRC_DT, SRC_T0, DST_T0, 1'b1, ALU_SUB, SRC_T1, SRC_Y, DST_T1,
                   JMP_NEXT);
      // T1 = dt*fy, x += dt*fx
      4'd6: w = uw(1'b1, SRC_DT, SRC_T1, DST_T1, 1'b1, ALU_ADD, SRC_X, SRC_T0, DST_X,
                   JMP_NEXT);
      // T2 = dt*fz, y += dt*fy
      4'd7: w = uw(1'b1, SRC_DT, SRC_T2, DST_T2, 1'b1, ALU_ADD, SRC_Y, SRC_T1, DST_Y,
                   JMP_NEXT);
      // z += dt*fz
      4'd8: w = uw(1'b0, SRC_X, SRC_X, DST_T0, 1'b1, ALU_ADD, SRC_Z, SRC_T2, DST_Z,
                   JMP_NEXT);
      4'd9: w = uw(1'b0, SRC_X, SRC_X, DST_T0, 1'b0, ALU_ADD, SRC_X, SRC_X, DST_T0,
                   JMP_DONE);
      default: w = uw(1'b0, SRC_X, SRC_X, DST_T0, 1'b0, ALU_ADD, SRC_X, SRC_X, DST_T0,
                      JMP_DONE);
    endcase
    return w;
  endfunction

  // Saturate a 33-bit sum to the 32-bit signed range.
  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? MIN_Q : MAX_Q;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Saturate a shifted product to the 32-bit signed range.
  function automatic logic signed [DATA_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if ((&v[PROD_W-1:DATA_W-1]) || !(|v[PROD_W-1:DATA_W-1])) begin
      r = v[DATA_W-1:0];
    end else begin
      r = v[PROD_W-1] ? MIN_Q : MAX_Q;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lorenz_seq.sv @@
// ----------------------------------------------------------------------------
// Lorenz microcode sequencer
// Program counter over the microcode table. Issues one control word per
// cycle and holds on the input-wait and output-wait words.
// ----------------------------------------------------------------------------
`default_nettype none

module lorenz_seq (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 out_free_i,
  output lorenz_pkg::ctrl_t   ctrl_o,
  output lorenz_pkg::seq_stat_t stat_o
);
  import lorenz_pkg::*;

  logic [UC_AW-1:0] pc_q, pc_d;
  uword_t           word;
  logic             exec;

  assign word = ucode(pc_q);

  always_comb begin
    pc_d            = pc_q;
    exec            = 1'b0;
    stat_o.in_ready = 1'b0;
    stat_o.done     = 1'b0;
    case (word.jump)
      JMP_WAIT_IN: begin
        stat_o.in_ready = 1'b1;
        if (in_valid_i) begin
          pc_d = pc_q + UC_AW'(1);
        end
      end
      JMP_NEXT: begin
        exec = 1'b1;
        pc_d = pc_q + UC_AW'(1);
      end
      JMP_DONE: begin
        if (out_free_i) begin
          exec        = 1'b1;
          stat_o.done = 1'b1;
          pc_d        = UC_ENTRY;
        end
      end
      default: begin
        pc_d = UC_ENTRY;
      end
    endcase
  end

  // Slot enables only fire when the word actually executes.
  always_comb begin
    ctrl_o        = word.ctrl;
    ctrl_o.mul_en = word.ctrl.mul_en & exec;
    ctrl_o.alu_en = word.ctrl.alu_en & exec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UC_ENTRY;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lorenz_dp.sv @@
// ----------------------------------------------------------------------------
// Lorenz datapath
// Point and scratch registers, one saturating fixed-point multiplier and one
// saturating adder, steered by the sequencer's control word.
// ----------------------------------------------------------------------------
`default_nettype none

module lorenz_dp (
  input  wire                                        clk_i,
  input  wire lorenz_pkg::ctrl_t                     ctrl_i,
  input  wire                                        load_i,
  input  wire logic signed [lorenz_pkg::DATA_W-1:0]  start_x_i,
  input  wire logic signed [lorenz_pkg::DATA_W-1:0]  start_y_i,
  input  wire logic signed [lorenz_pkg::DATA_W-1:0]  start_z_i,
  input  wire logic signed [lorenz_pkg::DATA_W-1:0]  sigma_i,
  input  wire logic signed [lorenz_pkg::DATA_W-1:0]  rho_i,
  input  wire logic signed [lorenz_pkg::DATA_W-1:0]  beta_i,
  output logic signed [lorenz_pkg::DATA_W-1:0]       x_o,
  output logic signed [lorenz_pkg::DATA_W-1:0]       y_o,
  output logic signed [lorenz_pkg::DATA_W-1:0]       z_o
);
  import lorenz_pkg::*;

  logic signed [DATA_W-1:0] x_q, y_q, z_q, t0_q, t1_q, t2_q, t3_q;
  logic signed [DATA_W-1:0] x_d, y_d, z_d, t0_d, t1_d, t2_d, t3_d;
  logic signed [DATA_W-1:0] mul_a, mul_b, alu_a, alu_b, mul_res, alu_res;
  logic signed [PROD_W-1:0] prod, prod_sh;
  logic signed [DATA_W:0]   sum;

  function automatic logic signed [DATA_W-1:0] pick(
    input src_e s, input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] y,
    input logic signed [DATA_W-1:0] z, input logic signed [DATA_W-1:0] t0,
    input logic signed [DATA_W-1:0] t1, input logic signed [DATA_W-1:0] t2,
    input logic signed [DATA_W-1:0] t3, input logic signed [DATA_W-1:0] sg,
    input logic signed [DATA_W-1:0] rh, input logic signed [DATA_W-1:0] bt);
    logic signed [DATA_W-1:0] r;
    case (s)
      SRC_X:     r = x;
      SRC_Y:     r = y;
      SRC_Z:     r = z;
      SRC_T0:    r = t0;
      SRC_T1:    r = t1;
      SRC_T2:    r = t2;
      SRC_T3:    r = t3;
      SRC_SIGMA: r = sg;
      SRC_RHO:   r = rh;
      SRC_BETA:  r = bt;
      SRC_DT:    r = DT_Q;
      default:   r = '0;
    endcase
    return r;
  endfunction

  assign mul_a = pick(ctrl_i.mul_a, x_q, y_q, z_q, t0_q, t1_q, t2_q, t3_q,
                      sigma_i, rho_i, beta_i);
  assign mul_b = pick(ctrl_i.mul_b, x_q, y_q, z_q, t0_q, t1_q, t2_q, t3_q,
                      sigma_i, rho_i, beta_i);
  assign alu_a = pick(ctrl_i.alu_a, x_q, y_q, z_q, t0_q, t1_q, t2_q, t3_q,
                      sigma_i, rho_i, beta_i);
  assign alu_b = pick(ctrl_i.alu_b, x_q, y_q, z_q, t0_q, t1_q, t2_q, t3_q,
                      sigma_i, rho_i, beta_i);

  // Exact product, arithmetic shift floors toward minus infinity.
  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_sh = prod >>> FRAC_BITS;
  assign mul_res = sat_prod(prod_sh);

  always_comb begin
    if (ctrl_i.alu_op == ALU_SUB) begin
      sum = {alu_a[DATA_W-1], alu_a} - {alu_b[DATA_W-1], alu_b};
    end else begin
      sum = {alu_a[DATA_W-1], alu_a} + {alu_b[DATA_W-1], alu_b};
    end
  end
  assign alu_res = sat_sum(sum);

  always_comb begin
    x_d  = x_q;
    y_d  = y_q;
    z_d  = z_q;
    t0_d = t0_q;
    t1_d = t1_q;
    t2_d = t2_q;
    t3_d = t3_q;
    if (ctrl_i.mul_en) begin
      case (ctrl_i.mul_dst)
        DST_X:   x_d  = mul_res;
        DST_Y:   y_d  = mul_res;
        DST_Z:   z_d  = mul_res;
        DST_T0:  t0_d = mul_res;
        DST_T1:  t1_d = mul_res;
        DST_T2:  t2_d = mul_res;
        DST_T3:  t3_d = mul_res;
        default: t3_d = t3_q;
      endcase
    end
    if (ctrl_i.alu_en) begin
      case (ctrl_i.alu_dst)
        DST_X:   x_d  = alu_res;
        DST_Y:   y_d  = alu_res;
        DST_Z:   z_d  = alu_res;
        DST_T0:  t0_d = alu_res;
        DST_T1:  t1_d = alu_res;
        DST_T2:  t2_d = alu_res;
        DST_T3:  t3_d = alu_res;
        default: t3_d = t3_q;
      endcase
    end
    if (load_i) begin
      x_d = start_x_i;
      y_d = start_y_i;
      z_d = start_z_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    z_q  <= z_d;
    t0_q <= t0_d;
    t1_q <= t1_d;
    t2_q <= t2_d;
    t3_q <= t3_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

`default_nettype wire

@@ hw/rtl/lorenz_euler_stepper_core.sv @@
// ----------------------------------------------------------------------------
// Lorenz Euler stepper core
// Advances a kept point of the Lorenz system by one forward Euler step of
// dt = 0.01 per input beat, in saturating signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-------------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o   | restart_i
//   out     | out       | out_valid_o/out_ready_i | pos_x/y/z_o, step_index_o,
//           |           |                         | run_last_o
//
// An input beat is taken only on the wait word, so a step ends before the next
// beat is taken: the microcode program runs 9 words after the beat on one
// multiplier and one adder, and the final word loads the result beat into the
// output register; the dependent multiplies on the shared multiplier set the
// program length. Reset returns the sequencer to its wait word and loads the
// register reset values; the first step afterwards reloads the start point.
// A stalled output register holds the sequencer on its final word, while a
// new input beat is taken as soon as the result has moved into it.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module lorenz_euler_stepper_core (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  wire                                          cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [lorenz_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [lorenz_pkg::DATA_W-1:0]           cfg_data_i,
  input  wire                                          in_valid_i,
  output logic                                         in_ready_o,
  input  wire                                          restart_i,
  output logic                                         out_valid_o,
  input  wire                                          out_ready_i,
  output logic signed [lorenz_pkg::DATA_W-1:0]         pos_x_o,
  output logic signed [lorenz_pkg::DATA_W-1:0]         pos_y_o,
  output logic signed [lorenz_pkg::DATA_W-1:0]         pos_z_o,
  output logic [lorenz_pkg::STEP_W-1:0]                step_index_o,
  output logic                                         run_last_o
);
  import lorenz_pkg::*;

  // Configuration registers.
  logic signed [DATA_W-1:0] sigma_q, rho_q, beta_q, start_x_q, start_y_q, start_z_q;
  logic [RUN_W-1:0]         run_length_q;

  // Run bookkeeping and the item in flight.
  logic [STEP_W-1:0] step_count_q, step_count_d;
  logic              need_reload_q, need_reload_d;
  logic [STEP_W-1:0] item_idx_q;
  logic              item_last_q;

  // Output register.
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [STEP_W-1:0]        out_idx_q;
  logic                     out_last_q;

  ctrl_t                    ctrl;
  seq_stat_t                stat;
  logic                     in_beat, reload, out_free, cur_last;
  logic [STEP_W-1:0]        cur_idx;
  logic [RUN_W-1:0]         run_len;
  logic signed [DATA_W-1:0] dp_x, dp_y, dp_z;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q      <= SIGMA_RST;
      rho_q        <= RHO_RST;
      beta_q       <= BETA_RST;
      start_x_q    <= START_RST;
      start_y_q    <= START_RST;
      start_z_q    <= START_RST;
      run_length_q <= RUN_LEN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SIGMA:      sigma_q      <= cfg_data_i;
        CFG_RHO:        rho_q        <= cfg_data_i;
        CFG_BETA:       beta_q       <= cfg_data_i;
        CFG_START_X:    start_x_q    <= cfg_data_i;
        CFG_START_Y:    start_y_q    <= cfg_data_i;
        CFG_START_Z:    start_z_q    <= cfg_data_i;
        CFG_RUN_LENGTH: run_length_q <= cfg_data_i[RUN_W-1:0];
        default:        run_length_q <= run_length_q;
      endcase
    end
  end

  // The output slot is free when empty or when its beat leaves this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  lorenz_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .stat_o     (stat)
  );

  assign in_ready_o = stat.in_ready;
  assign in_beat    = in_valid_i && stat.in_ready;

  // A new run starts on request, or when the previous run has ended.
  assign reload = in_beat && (restart_i || need_reload_q);

  lorenz_dp u_dp (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .load_i    (reload),
    .start_x_i (start_x_q),
    .start_y_i (start_y_q),
    .start_z_i (start_z_q),
    .sigma_i   (sigma_q),
    .rho_i     (rho_q),
    .beta_i    (beta_q),
    .x_o       (dp_x),
    .y_o       (dp_y),
    .z_o       (dp_z)
  );

  // A run length of zero behaves as one, anything above the maximum as the
  // maximum.
  always_comb begin
    if (run_length_q == '0) begin
      run_len = RUN_W'(1);
    end else if (run_length_q > MAX_RUN) begin
      run_len = MAX_RUN;
    end else begin
      run_len = run_length_q;
    end
  end

  // The step index and last flag are settled when the beat is taken, so the
  // run bookkeeping moves on right away.
  assign cur_idx  = (restart_i || need_reload_q) ? '0 : step_count_q;
  assign cur_last = ({1'b0, cur_idx} + RUN_W'(1)) >= run_len;

  always_comb begin
    step_count_d  = step_count_q;
    need_reload_d = need_reload_q;
    if (in_beat) begin
      need_reload_d = cur_last;
      step_count_d  = cur_last ? cur_idx : cur_idx + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q  <= '0;
      need_reload_q <= 1'b1;
    end else begin
      step_count_q  <= step_count_d;
      need_reload_q <= need_reload_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      item_idx_q  <= cur_idx;
      item_last_q <= cur_last;
    end
  end

  // Output register: loaded on the final microcode word, emptied by a beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      pos_x_q    <= dp_x;
      pos_y_q    <= dp_y;
      pos_z_q    <= dp_z;
      out_idx_q  <= item_idx_q;
      out_last_q <= item_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pos_x_o      = pos_x_q;
  assign pos_y_o      = pos_y_q;
  assign pos_z_o      = pos_z_q;
  assign step_index_o = out_idx_q;
  assign run_last_o   = out_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/lorenz_checker.sv @@
// ----------------------------------------------------------------------------
// Lorenz stepper port checker
// Watches the ports of the stepper core for handshake and timing slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lorenz_euler_stepper_core_defines.svh"

module lorenz_checker (
  input wire                                    clk_i,
  input wire                                    rst_ni,
  input wire                                    cfg_valid_i,
  input wire                                    cfg_ready_o,
  input wire                                    in_valid_i,
  input wire                                    in_ready_o,
  input wire                                    out_valid_o,
  input wire                                    out_ready_i,
  input wire [lorenz_pkg::DATA_W-1:0]           pos_x_o,
  input wire [lorenz_pkg::DATA_W-1:0]           pos_y_o,
  input wire [lorenz_pkg::DATA_W-1:0]           pos_z_o,
  input wire [lorenz_pkg::STEP_W-1:0]           step_index_o,
  input wire                                    run_last_o
);

  // A stalled result beat keeps its payload.
  `LORENZ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(pos_x_o) && $stable(pos_y_o) && $stable(pos_z_o) && $stable(step_index_o) && $stable(run_last_o), "stalled result changed")

  // Once a step starts, no second input beat is taken in the next cycle.
  `LORENZ_ASSERT_NEXT(a_in_busy, in_valid_i && in_ready_o, !in_ready_o, "input taken while a step runs")

  // A step cannot produce its result in the cycle right after it was taken.
  `LORENZ_ASSERT_NEXT(a_no_early_out, in_valid_i && in_ready_o, !$rose(out_valid_o), "result appeared too early")

  // Configuration writes are never back-pressured.
  `LORENZ_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o, "configuration write stalled")

endmodule

bind lorenz_euler_stepper_core lorenz_checker u_lorenz_checker (.*);

`default_nettype wire

@@ bench/lorenz_euler_stepper_checker.sv @@
// ----------------------------------------------------------------------------
// Lorenz Euler stepper checker
// Watches the configuration, step and result channels of the stepper core,
// keeps its own copy of the registers and the integrated point, predicts every
// result beat and compares it with what the core delivers.
// ----------------------------------------------------------------------------
module lorenz_euler_stepper_checker
  import lorenz_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     restart_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [DATA_W-1:0] pos_x_i,
  input  logic signed [DATA_W-1:0] pos_y_i,
  input  logic signed [DATA_W-1:0] pos_z_i,
  input  logic [STEP_W-1:0]        step_index_i,
  input  logic                     run_last_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       steps_checked_o,
  output int                       runs_closed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic [STEP_W-1:0]        idx;
    logic                     last;
  } step_result_t;

  // Register copy.
  logic signed [DATA_W-1:0] coef_sigma, coef_rho, coef_beta;
  logic signed [DATA_W-1:0] origin_x, origin_y, origin_z;
  logic [RUN_W-1:0]         run_len;

  // Integrator state.
  logic signed [DATA_W-1:0] pt_x, pt_y, pt_z;
  logic [STEP_W-1:0]        step_cnt;
  logic                     reload_due;

  step_result_t expected_steps[$];
  int mismatches    = 0;
  int steps_checked = 0;
  int runs_closed   = 0;

  initial begin
    fail_count_o    = 0;
    pending_o       = 0;
    steps_checked_o = 0;
    runs_closed_o   = 0;
  end

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    logic signed [DATA_W-1:0] r;
    if (v > longint'(MAX_Q)) begin
      r = MAX_Q;
    end else if (v < longint'(MIN_Q)) begin
      r = MIN_Q;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Exact product, arithmetic shift (floor), then saturation.
  function automatic logic signed [DATA_W-1:0] qmul(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> FRAC_BITS);
  endfunction

  // One forward Euler step on the kept point; updates the integrator state.
  function automatic step_result_t advance_point(input logic restart_bit);
    logic [RUN_W-1:0]         eff_len;
    logic signed [DATA_W-1:0] x, y, z, fx, fy, fz;
    step_result_t             r;
    eff_len = run_len;
    if (eff_len == '0) eff_len = RUN_W'(1);
    if (eff_len > MAX_RUN) eff_len = MAX_RUN;
    if (restart_bit || reload_due) begin
      pt_x     = origin_x;
      pt_y     = origin_y;
      pt_z     = origin_z;
      step_cnt = '0;
    end
    x  = pt_x;
    y  = pt_y;
    z  = pt_z;
    fx = qmul(coef_sigma, clamp32(longint'(y) - longint'(x)));
    fy = clamp32(longint'(qmul(x, clamp32(longint'(coef_rho) - longint'(z)))) - longint'(y));
    fz = clamp32(longint'(qmul(x, y)) - longint'(qmul(coef_beta, z)));
    r.x    = clamp32(longint'(x) + longint'(qmul(DT_Q, fx)));
    r.y    = clamp32(longint'(y) + longint'(qmul(DT_Q, fy)));
    r.z    = clamp32(longint'(z) + longint'(qmul(DT_Q, fz)));
    r.idx  = step_cnt;
    r.last = ({1'b0, step_cnt} + RUN_W'(1)) >= eff_len;
    pt_x = r.x;
    pt_y = r.y;
    pt_z = r.z;
    if (r.last) begin
      reload_due = 1'b1;
    end else begin
      reload_due = 1'b0;
      step_cnt   = step_cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic void note_failure(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, what);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    step_result_t want;
    step_result_t seen;
    if (!rst_ni) begin
      coef_sigma = SIGMA_RST;
      coef_rho   = RHO_RST;
      coef_beta  = BETA_RST;
      origin_x   = START_RST;
      origin_y   = START_RST;
      origin_z   = START_RST;
      run_len    = RUN_LEN_RST;
      pt_x       = '0;
      pt_y       = '0;
      pt_z       = '0;
      step_cnt   = '0;
      reload_due = 1'b1;
      expected_steps.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SIGMA:      coef_sigma = cfg_data_i;
          CFG_RHO:        coef_rho   = cfg_data_i;
          CFG_BETA:       coef_beta  = cfg_data_i;
          CFG_START_X:    origin_x   = cfg_data_i;
          CFG_START_Y:    origin_y   = cfg_data_i;
          CFG_START_Z:    origin_z   = cfg_data_i;
          CFG_RUN_LENGTH: run_len    = cfg_data_i[RUN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_steps.insert(expected_steps.size(), advance_point(restart_i));
      end
      if (out_valid_i && out_ready_i) begin
        seen = '{x: pos_x_i, y: pos_y_i, z: pos_z_i, idx: step_index_i, last: run_last_i};
        if (expected_steps.size() == 0) begin
          note_failure($sformatf("Result beat with no step pending: x=%h y=%h z=%h idx=%0d last=%b",
                                 seen.x, seen.y, seen.z, seen.idx, seen.last));
        end else begin
          want = expected_steps.pop_front();
          steps_checked++;
          if (want.last) runs_closed++;
          if ((seen.x !== want.x) || (seen.y !== want.y) || (seen.z !== want.z) ||
              (seen.idx !== want.idx) || (seen.last !== want.last)) begin
            note_failure($sformatf({"Step %0d wrong: expected x=%h y=%h z=%h idx=%0d last=%b,",
                                    " got x=%h y=%h z=%h idx=%0d last=%b"},
                                   steps_checked, want.x, want.y, want.z, want.idx, want.last,
                                   seen.x, seen.y, seen.z, seen.idx, seen.last));
          end
        end
      end
    end
    fail_count_o    <= mismatches;
    pending_o       <= expected_steps.size();
    steps_checked_o <= steps_checked;
    runs_closed_o   <= runs_closed;
  end

endmodule

@@ bench/lorenz_euler_stepper_core_tb.sv @@
// ----------------------------------------------------------------------------
// Lorenz Euler stepper core testbench
// Drives configuration writes and step beats into the stepper core, pulls
// result beats with random back-pressure, and leaves prediction and comparison
// to the checker that sits beside the core. Directed extremes come first, then
// randomized settings under three idle mixes and one full-length run.
// ----------------------------------------------------------------------------
module lorenz_euler_stepper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lorenz_pkg::*;

  localparam int CLK_PERIOD     = 8;
  // Settling wait after a drain: one core step with a little margin on top.
  localparam int LATENCY_CYCLES = 12;
  // Longest legal silence is the long output hold plus a step; take it many
  // times over.
  localparam int LONG_HOLD      = 300;
  localparam int STALL_LIMIT    = 4000;
  localparam int ONE            = int'(ONE_Q);
  // Register index past the last real register; the core must ignore it.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(7);

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic                     restart   = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] pos_x, pos_y, pos_z;
  logic [STEP_W-1:0]        step_index;
  logic                     run_last;

  // Idle percentages of the two sides and the remaining length of a forced
  // output hold, which the receiver process counts down itself.
  int send_idle_pct = 24;
  int recv_idle_pct = 61;
  int hold_cycles   = 0;

  int fail_count, pending, steps_checked, runs_closed;
  int quiet_cycles = 0;

  lorenz_euler_stepper_core DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .restart_i    (restart),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pos_x_o      (pos_x),
    .pos_y_o      (pos_y),
    .pos_z_o      (pos_z),
    .step_index_o (step_index),
    .run_last_o   (run_last)
  );

  lorenz_euler_stepper_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .restart_i       (restart),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .pos_x_i         (pos_x),
    .pos_y_i         (pos_y),
    .pos_z_i         (pos_z),
    .step_index_i    (step_index),
    .run_last_i      (run_last),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .steps_checked_o (steps_checked),
    .runs_closed_o   (runs_closed)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Result side. Ready changes only on the falling edge. A forced hold keeps
  // ready low for a counted stretch so the core fills up and stalls its input.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any accepted beat on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: %0d cycles without an accepted beat, %0d steps pending",
               quiet_cycles, pending);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One configuration beat. The core is idle whenever this is called.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_setting(input logic [DATA_W-1:0] sig, input logic [DATA_W-1:0] rh,
                              input logic [DATA_W-1:0] bt, input logic [DATA_W-1:0] sx,
                              input logic [DATA_W-1:0] sy, input logic [DATA_W-1:0] sz,
                              input logic [RUN_W-1:0] len);
    write_reg(CFG_SIGMA, sig);
    write_reg(CFG_RHO, rh);
    write_reg(CFG_BETA, bt);
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_START_Z, sz);
    write_reg(CFG_RUN_LENGTH, DATA_W'(len));
  endtask

  // Offer one step beat, possibly after a few idle cycles. Valid is left high
  // after acceptance; the next call or close_burst decides whether it drops,
  // so valid is never lowered and raised in the same time step.
  task automatic offer_step(input logic restart_bit);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    restart  <= restart_bit;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic close_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every predicted result has been delivered, then let the core
  // settle before the registers may be touched.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  task automatic directed_burst(input int n_items, input logic [15:0] restarts);
    for (int i = 0; i < n_items; i++) offer_step(restarts[i]);
    close_burst();
    drain();
  endtask

  // Random burst. Optionally starts a long output hold early on, or pauses the
  // sender halfway until the core has handed back everything.
  task automatic run_burst(input int n_items, input int restart_pct, input bit hold_early,
                           input bit pause_mid);
    for (int i = 0; i < n_items; i++) begin
      if (hold_early && i == 4) hold_cycles = LONG_HOLD;
      if (pause_mid && i == n_items / 2) begin
        close_burst();
        drain();
      end
      offer_step($urandom_range(99) < restart_pct);
    end
    close_burst();
    drain();
  endtask

  // Fixed-point value: mostly moderate, sometimes a bound, zero or raw bits.
  function automatic logic [DATA_W-1:0] rand_q(input int span);
    logic [DATA_W-1:0] r;
    case ($urandom_range(11))
      0:       r = MIN_Q;
      1:       r = MAX_Q;
      2:       r = '0;
      3, 4:    r = $urandom();
      default: r = DATA_W'($urandom_range(0, 2 * span * ONE) - span * ONE);
    endcase
    return r;
  endfunction

  task automatic pick_setting();
    logic [RUN_W-1:0] len;
    case ($urandom_range(9))
      0:       len = '0;
      1:       len = RUN_W'(1);
      2:       len = '1;
      3:       len = MAX_RUN;
      4:       len = RUN_W'($urandom_range(2047));
      default: len = RUN_W'($urandom_range(2, 40));
    endcase
    if ($urandom_range(3) == 0) write_reg(CFG_IDX_SPARE, $urandom());
    load_setting(rand_q(20), rand_q(40), rand_q(5), rand_q(25), rand_q(25), rand_q(40), len);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: the first beat reloads the start point by itself, the
    // fifth forces a reload with restart.
    directed_burst(7, 16'h0010);

    // A zero run length behaves as one, so every step ends a run. The write
    // to the spare index must change nothing.
    write_reg(CFG_RUN_LENGTH, '0);
    write_reg(CFG_IDX_SPARE, '1);
    directed_burst(3, 16'h0000);

    // Saturation in both directions: bounds in all but the run length, opposite
    // signs between coordinates so differences and products overflow.
    load_setting(MAX_Q, MIN_Q, MAX_Q, MAX_Q, MIN_Q, MAX_Q, RUN_W'(3));
    directed_burst(4, 16'h0000);
    load_setting(MIN_Q, MAX_Q, MIN_Q, MIN_Q, MAX_Q, MIN_Q, RUN_W'(2));
    directed_burst(3, 16'h0002);

    // All-zero system stays at the origin.
    load_setting('0, '0, '0, '0, '0, '0, RUN_W'(1));
    directed_burst(2, 16'h0001);

    // Back to the classic coefficients with the longest legal run.
    load_setting(SIGMA_RST, RHO_RST, BETA_RST, START_RST, START_RST, START_RST, MAX_RUN);
    directed_burst(3, 16'h0005);

    // Random part under three idle mixes.
    for (int mix = 0; mix < 3; mix++) begin
      case (mix)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (mix == 2) begin
        // One full-length run: an overlong run length acts as the maximum, so
        // the step index climbs through every bit and the run closes once.
        load_setting(SIGMA_RST, RHO_RST, BETA_RST, DATA_W'($urandom_range(0, 10 * ONE)),
                     DATA_W'($urandom_range(0, 10 * ONE)), DATA_W'($urandom_range(0, 30 * ONE)),
                     '1);
        offer_step(1'b1);
        run_burst(1029, 0, 1'b0, 1'b0);
      end
      for (int p = 0; p < 3; p++) begin
        pick_setting();
        run_burst(60, $urandom_range(15), (mix == 0) && (p == 0), (mix == 1) && (p == 0));
      end
    end

    drain();
    repeat (LATENCY_CYCLES) @(posedge clk);

    $display("Run covered %0d checked steps and %0d closed runs over directed extremes,",
             steps_checked, runs_closed);
    $display("random settings, clamped run lengths, a %0d-cycle output hold and a full drain.",
             LONG_HOLD);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ lorenz_euler_stepper_core.f @@
+incdir+hw/rtl
hw/rtl/lorenz_pkg.sv
hw/rtl/lorenz_seq.sv
hw/rtl/lorenz_dp.sv
hw/rtl/lorenz_euler_stepper_core.sv
hw/rtl/lorenz_checker.sv
bench/lorenz_euler_stepper_checker.sv
bench/lorenz_euler_stepper_core_tb.sv
